// ----- src/utf8_to_cp437_transcoder_defines.svh -----
// assertion macros for the utf8 to cp437 transcoder
// no dependencies; included by the modules that carry assertions
`ifndef UTF8_TO_CP437_TRANSCODER_DEFINES_SVH
`define UTF8_TO_CP437_TRANSCODER_DEFINES_SVH
`ifndef SYNTHESIS
`define U2C_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
`define U2C_ASSERT_NEVER(lbl, ck, rn, expr, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) !(expr)) else $error(msg);
`else
`define U2C_ASSERT(lbl, ck, rn, prop, msg)
`define U2C_ASSERT_NEVER(lbl, ck, rn, expr, msg)
`endif
`endif

// ----- src/u2c437_pkg.sv -----
// shared types, byte codes and mapping tables of the utf8 to cp437 transcoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package u2c437_pkg;

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [7:0] B_C3   = 8'hC3;
	localparam logic [7:0] B_C2   = 8'hC2;
	localparam logic [7:0] B_E2   = 8'hE2;
	localparam logic [7:0] B_82   = 8'h82;
	localparam logic [7:0] B_AC   = 8'hAC;
	localparam logic [7:0] B_B3   = 8'hB3;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_3   = 8'h33;
	localparam logic [7:0] CH_E   = 8'h45;
	localparam logic [7:0] CH_U   = 8'h55;
	localparam logic [7:0] CH_R   = 8'h52;
	localparam logic [7:0] CH_O   = 8'h4F;

	typedef enum logic [2:0] {
		PFX_NONE = 3'd0,
		PFX_C3   = 3'd1,
		PFX_C2   = 3'd2,
		PFX_E2   = 3'd3,
		PFX_E282 = 3'd4
	} pfx_state_t;

	// one queued transaction group: up to four characters, index of the last one
	typedef struct packed {
		logic [3:0][7:0] chars;
		logic [1:0]      last_idx;
	} job_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] ch;
	} map_t;

	function automatic map_t map_c3(input logic [7:0] b);
		map_t r;
		r.hit = 1'b1;
		unique case (b)
			8'hA4: r.ch = 8'h84;
			8'h84: r.ch = 8'h8E;
			8'hB6: r.ch = 8'h94;
			8'h96: r.ch = 8'h99;
			8'hBC: r.ch = 8'h81;
			8'h9C: r.ch = 8'h9A;
			8'h9F: r.ch = 8'hE1;
			default: begin
				r.hit = 1'b0;
				r.ch  = 8'h00;
			end
		endcase
		return r;
	endfunction

	function automatic map_t map_c2(input logic [7:0] b);
		map_t r;
		r.hit = 1'b1;
		unique case (b)
			8'hA7: r.ch = 8'h15;
			8'hB2: r.ch = 8'hFD;
			8'hB5: r.ch = 8'hE6;
			8'hB4: r.ch = 8'h60;
			default: begin
				r.hit = 1'b0;
				r.ch  = 8'h00;
			end
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- src/u2c437_front.sv -----
// front end: accepts bytes, tracks held prefixes, builds character groups
// depends on u2c437_pkg and utf8_to_cp437_transcoder_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_to_cp437_transcoder_defines.svh"
module u2c437_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output      logic              in_ready,
	input  wire logic [7:0]        in_byte,
	input  wire logic              buffer_end,
	output      logic              job_valid,
	input  wire logic              job_ready,
	output      u2c437_pkg::job_t  job
);

	u2c437_pkg::pfx_state_t state_q, state_d;
	logic [3:0][7:0] chars;
	logic [2:0]      n;
	logic [1:0]      lead_n;
	logic            do_fresh;
	logic            accept;
	u2c437_pkg::map_t m3, m2;

	assign in_ready  = job_ready;
	assign accept    = in_valid & in_ready;
	assign job_valid = accept & (n != 3'd0);
	assign job.chars    = chars;
	assign job.last_idx = 2'(n - 3'd1);

	assign m3 = u2c437_pkg::map_c3(in_byte);
	assign m2 = u2c437_pkg::map_c2(in_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= u2c437_pkg::PFX_NONE;
		end else if (accept) begin
			state_q <= state_d;
		end
	end

	always_comb begin
		chars    = '0;
		n        = 3'd0;
		lead_n   = 2'd0;
		do_fresh = 1'b0;
		state_d  = u2c437_pkg::PFX_NONE;
		unique case (state_q)
			u2c437_pkg::PFX_C3: begin
				if (m3.hit) begin
					chars[0] = m3.ch;
					n        = 3'd1;
				end else begin
					chars[0] = u2c437_pkg::B_C3;
					lead_n   = 2'd1;
					do_fresh = 1'b1;
				end
			end
			u2c437_pkg::PFX_C2: begin
				if (in_byte == u2c437_pkg::B_B3) begin
					chars[0] = u2c437_pkg::CH_CARET;
					chars[1] = u2c437_pkg::CH_3;
					n        = 3'd2;
				end else if (m2.hit) begin
					chars[0] = m2.ch;
					n        = 3'd1;
				end else begin
					chars[0] = u2c437_pkg::B_C2;
					lead_n   = 2'd1;
					do_fresh = 1'b1;
				end
			end
			u2c437_pkg::PFX_E2: begin
				if (in_byte == u2c437_pkg::B_82 && !buffer_end) begin
					state_d = u2c437_pkg::PFX_E282;
				end else begin
					chars[0] = u2c437_pkg::B_E2;
					lead_n   = 2'd1;
					do_fresh = 1'b1;
				end
			end
			u2c437_pkg::PFX_E282: begin
				if (in_byte == u2c437_pkg::B_AC) begin
					chars[0] = u2c437_pkg::CH_E;
					chars[1] = u2c437_pkg::CH_U;
					chars[2] = u2c437_pkg::CH_R;
					chars[3] = u2c437_pkg::CH_O;
					n        = 3'd4;
				end else begin
					chars[0] = u2c437_pkg::B_E2;
					chars[1] = u2c437_pkg::B_82;
					lead_n   = 2'd2;
					do_fresh = 1'b1;
				end
			end
			default: begin
				do_fresh = 1'b1;
			end
		endcase
		if (do_fresh) begin
			n = {1'b0, lead_n};
			if (!buffer_end && in_byte == u2c437_pkg::B_C3) begin
				state_d = u2c437_pkg::PFX_C3;
			end else if (!buffer_end && in_byte == u2c437_pkg::B_C2) begin
				state_d = u2c437_pkg::PFX_C2;
			end else if (!buffer_end && in_byte == u2c437_pkg::B_E2) begin
				state_d = u2c437_pkg::PFX_E2;
			end else begin
				chars[lead_n] = in_byte;
				n             = 3'({1'b0, lead_n} + 3'd1);
			end
		end
	end

	`U2C_ASSERT(a_end_clears, clk, arst_n, accept && buffer_end |=> state_q == u2c437_pkg::PFX_NONE, "prefix held past buffer end")
	`U2C_ASSERT(a_c3_held, clk, arst_n, accept && !buffer_end && state_q == u2c437_pkg::PFX_NONE && in_byte == u2c437_pkg::B_C3 |-> !job_valid ##1 state_q == u2c437_pkg::PFX_C3, "c3 prefix not held")
	`U2C_ASSERT(a_euro_len, clk, arst_n, job_valid && state_q == u2c437_pkg::PFX_E282 |-> job.last_idx >= 2'd1, "e2 82 group too short")

endmodule
`default_nettype wire

// ----- src/u2c437_queue.sv -----
// short register queue of character groups between front and back end
// depends on u2c437_pkg
`timescale 1ns / 1ps
`default_nettype none
module u2c437_queue #(
	parameter int DEPTH = u2c437_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_valid,
	output      logic             wr_ready,
	input  wire u2c437_pkg::job_t wr_data,
	output      logic             rd_valid,
	input  wire logic             rd_ready,
	output      u2c437_pkg::job_t rd_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	u2c437_pkg::job_t entries_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push, pop;

	assign wr_ready = count_q != CW'(DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_data  = entries_q[rd_ptr_q];
	assign push     = wr_valid & wr_ready;
	assign pop      = rd_valid & rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= CW'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= CW'(count_q - 1'b1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- src/u2c437_back.sv -----
// back end: sends the characters of each queued group, one per transaction
// depends on u2c437_pkg and utf8_to_cp437_transcoder_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_to_cp437_transcoder_defines.svh"
module u2c437_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             job_valid,
	output      logic             job_ready,
	input  wire u2c437_pkg::job_t job,
	output      logic             out_valid,
	input  wire logic             out_ready,
	output      logic [7:0]       out_char,
	output      logic             run_last
);

	u2c437_pkg::job_t cur_q;
	logic [1:0] idx_q;
	logic       busy_q;
	logic       done, pop, step;

	assign out_valid = busy_q;
	assign out_char  = cur_q.chars[idx_q];
	assign run_last  = idx_q == cur_q.last_idx;
	assign step      = busy_q & out_ready;
	assign done      = step & run_last;
	assign pop       = job_valid & (!busy_q | done);
	assign job_ready = !busy_q | done;

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (step) begin
			idx_q <= 2'(idx_q + 2'd1);
		end
	end

	`U2C_ASSERT_NEVER(a_idx_range, clk, arst_n, busy_q && idx_q > cur_q.last_idx, "character index past group end")
	`U2C_ASSERT(a_refill, clk, arst_n, done |=> busy_q == $past(job_valid), "back end did not refill after group end")
	`U2C_ASSERT(a_advance, clk, arst_n, step && !run_last |=> idx_q == 2'($past(idx_q) + 2'd1), "character index did not advance")

endmodule
`default_nettype wire

// ----- src/utf8_to_cp437_transcoder.sv -----
// UTF-8 to code page 437 transcoder. One input byte is taken per cycle while the
// queue between front and back end has room; one character leaves per cycle while
// the output is ready and a group is waiting. A byte that yields two to four
// characters (C2 B3, E2 82 AC, broken prefixes) keeps the back end busy until all are
// sent; the QUEUE_DEPTH-entry queue and the back end's group absorb that, and a full
// queue holds the input off until the back end takes a group from it. A prefix byte
// not marked as buffer end yields no character until the byte that completes or
// breaks it arrives. A byte's characters pass a queue entry and the back end register.
// depends on u2c437_pkg, u2c437_front, u2c437_queue, u2c437_back
`timescale 1ns / 1ps
`default_nettype none
module utf8_to_cp437_transcoder #(
	parameter int QUEUE_DEPTH = u2c437_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output      logic       s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] in_byte
	input  wire logic       s_tlast,   // buffer_end
	output      logic       m_tvalid,
	input  wire logic       m_tready,
	output      logic [7:0] m_tdata,   // [7:0] out_char
	output      logic       m_tlast    // run_last
);

	u2c437_pkg::job_t fj, bj;
	logic fj_valid, fj_ready, bj_valid, bj_ready;

	u2c437_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_byte    (s_tdata),
		.buffer_end (s_tlast),
		.job_valid  (fj_valid),
		.job_ready  (fj_ready),
		.job        (fj)
	);

	u2c437_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fj_valid),
		.wr_ready (fj_ready),
		.wr_data  (fj),
		.rd_valid (bj_valid),
		.rd_ready (bj_ready),
		.rd_data  (bj)
	);

	u2c437_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (bj_valid),
		.job_ready (bj_ready),
		.job       (bj),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_char  (m_tdata),
		.run_last  (m_tlast)
	);

endmodule
`default_nettype wire
